/* design/pfp_pkg.sv */
// ----------------------------------------------------------------------------
// pfp_pkg: shared types, constants and table math for foot placement
// Fixed-point constants of the pendulum law and the hyperbolic series
// used to build the interpolation tables at elaboration.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int DATA_W       = 32;
  localparam int PHASE_W      = 17;
  localparam int PHASE_FRAC_W = 16;
  localparam logic [PHASE_W-1:0] PHASE_ONE = 17'd65536;

  // l*Tw and 1/(m*H*l), both Q30
  localparam logic [63:0] LTW_Q30     = 64'd2302527748;
  localparam logic [63:0] INV_MHL_Q30 = 64'd33564545;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam int          Q30_SHIFT   = 30;
  localparam int          HYP_TERMS   = 40;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int FRAC_BITS_DEF     = 16;

  // input/lut, interp, coef, product, sum, round
  localparam int PIPE_STAGES = 6;

  typedef struct packed {
    logic signed [DATA_W-1:0] mom_x;
    logic signed [DATA_W-1:0] mom_y;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] tgt_vx;
    logic signed [DATA_W-1:0] tgt_oy;
  } item_t;

  typedef struct packed {
    logic [63:0] ch;
    logic [63:0] sh;
  } hyp_t;

  typedef struct packed {
    logic ld_lut;  // load table read stage
    logic ld_mix;  // load interpolation stage
  } interp_ctl_t;

  // Taylor series of cosh/sinh in Q30, each term truncated (64-bit wrap)
  function automatic hyp_t hyp_q30(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] c;
    logic [63:0] s;
    hyp_t        res;
    term = Q30_ONE;
    c    = Q30_ONE;
    s    = '0;
    for (int n = 1; n <= HYP_TERMS; n++) begin
      term = (term * x) >> Q30_SHIFT;
      term = term / 64'(n);
      if (n[0]) begin
        s = s + term;
      end else begin
        c = c + term;
      end
    end
    res.ch = c;
    res.sh = s;
    return res;
  endfunction

endpackage

/* design/pendulum_foot_placement_unit.sv */
// ----------------------------------------------------------------------------
// pendulum_foot_placement_unit: swing foot placement, pendulum law
// Predicts end-of-step angular momentum from cosh/sinh of the remaining
// step time and places the swing foot in x and y, Q16.16, saturated.
// ----------------------------------------------------------------------------
//
//  channel | ports                                          | handshake
//  --------+------------------------------------------------+------------------
//  input   | in_momentum_x/y, in_position_x/y, in_phase,     | in_valid/in_ready
//          | in_target_velocity_x, in_target_offset_y        |
//  result  | out_foot_x, out_foot_y, out_saturated           | out_valid/out_ready
//
//  One item per cycle sustained while out_ready is high; an item passes
//  through six register stages in order before it reaches the outputs:
//  table read, interpolation, coefficient multiply, placement products,
//  three-term sum, round and saturate.
//  Reset (rst_n low, synchronous) empties every stage; tables are constant.
//  Each stage has its own valid bit and takes a new item whenever it is empty
//  or its successor moves, so bubbles close up behind a stalled result and the
//  input keeps accepting until every stage holds an item.
//
module pendulum_foot_placement_unit #(
  parameter int TABLE_ENTRIES = pfp_pkg::TABLE_ENTRIES_DEF,
  parameter int FRAC_BITS     = pfp_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [pfp_pkg::DATA_W-1:0]    in_momentum_x,
  input  logic signed [pfp_pkg::DATA_W-1:0]    in_momentum_y,
  input  logic signed [pfp_pkg::DATA_W-1:0]    in_position_x,
  input  logic signed [pfp_pkg::DATA_W-1:0]    in_position_y,
  input  logic        [pfp_pkg::PHASE_W-1:0]   in_phase,
  input  logic signed [pfp_pkg::DATA_W-1:0]    in_target_velocity_x,
  input  logic signed [pfp_pkg::DATA_W-1:0]    in_target_offset_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [pfp_pkg::DATA_W-1:0]    out_foot_x,
  output logic signed [pfp_pkg::DATA_W-1:0]    out_foot_y,
  output logic                                 out_saturated
);

  localparam int NS     = pfp_pkg::PIPE_STAGES;
  localparam int DW     = pfp_pkg::DATA_W;
  localparam int TAB_W  = FRAC_BITS + 3;
  localparam int COEF_W = FRAC_BITS + 3;
  localparam int KM_W   = COEF_W + TAB_W + 1;
  localparam int PROD_W = DW + COEF_W + 1;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RS_W   = ACC_W - FRAC_BITS;

  // step constants C = cosh(l*Tw), S = sinh(l*Tw); last table entry
  localparam logic [63:0]   HALF_Q  = 64'd1 << (29 - FRAC_BITS);
  localparam pfp_pkg::hyp_t HYP_END = pfp_pkg::hyp_q30(pfp_pkg::LTW_Q30);
  localparam logic [63:0]   CC_Q    = (HYP_END.ch + HALF_Q) >> (30 - FRAC_BITS);
  localparam logic [63:0]   SS_RAW  = (HYP_END.sh + HALF_Q) >> (30 - FRAC_BITS);
  localparam logic [63:0]   SS_Q    = (SS_RAW < 64'd1) ? 64'd1 : SS_RAW;
  localparam logic [63:0]   ONE_Q   = 64'd1 << FRAC_BITS;
  localparam logic [63:0]   COTH_Q  = (CC_Q << FRAC_BITS) / SS_Q;
  localparam logic [63:0]   KL_Q    = (COTH_Q * pfp_pkg::INV_MHL_Q30
                                       + (64'd1 << 29)) >> pfp_pkg::Q30_SHIFT;
  localparam logic [63:0]   KV_Q    = (64'd1 << (2 * FRAC_BITS - 2)) / (ONE_Q + CC_Q);
  localparam logic [63:0]   KP_Q    = (64'd1 << (2 * FRAC_BITS)) / (ONE_Q + CC_Q);

  localparam logic [COEF_W-1:0] COTH_C = COTH_Q[COEF_W-1:0];
  localparam logic [COEF_W-1:0] KL_C   = KL_Q[COEF_W-1:0];
  localparam logic signed [COEF_W:0] KV_S = {1'b0, KV_Q[COEF_W-1:0]};
  localparam logic signed [COEF_W:0] KP_S = {1'b0, KP_Q[COEF_W-1:0]};
  localparam logic [KM_W-1:0] HALF_F = KM_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] ROUND_F = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DW-1:0] SAT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SAT_MIN = {1'b1, {(DW-1){1'b0}}};

  // ---------------------------------------------------------------- control
  // take[k]: stage k may load this cycle (empty or its content moves on)
  logic [NS:1]   vld_r, vld_nxt;
  logic [NS+1:1] take;
  logic [NS:1]   load;

  always_comb begin
    take[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      take[k] = !vld_r[k] || take[k+1];
    end
    load[1] = take[1] && in_valid;
    for (int k = 2; k <= NS; k++) begin
      load[k] = take[k] && vld_r[k-1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (take[1]) begin
      vld_nxt[1] = in_valid;
    end
    for (int k = 2; k <= NS; k++) begin
      if (take[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready = take[1];

  // ---------------------------------------------------------------- stage 1
  // phase clamp, remaining fraction r = 1 - phase, table read (in submodule)
  logic                         ph_clamp;
  logic [pfp_pkg::PHASE_W-1:0]  ph_eff;
  logic [pfp_pkg::PHASE_W-1:0]  rem_nxt;
  pfp_pkg::item_t               item_nxt;
  pfp_pkg::item_t               item1_r, item2_r, item3_r;
  logic                         sat1_r, sat2_r, sat3_r, sat4_r, sat5_r;

  assign ph_clamp = in_phase > pfp_pkg::PHASE_ONE;
  assign ph_eff   = ph_clamp ? pfp_pkg::PHASE_ONE : in_phase;
  assign rem_nxt  = pfp_pkg::PHASE_ONE - ph_eff;

  always_comb begin
    item_nxt.mom_x  = in_momentum_x;
    item_nxt.mom_y  = in_momentum_y;
    item_nxt.pos_x  = in_position_x;
    item_nxt.pos_y  = in_position_y;
    item_nxt.tgt_vx = in_target_velocity_x;
    item_nxt.tgt_oy = in_target_offset_y;
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      item1_r <= item_nxt;
      sat1_r  <= ph_clamp;
    end
  end

  // ---------------------------------------------------------------- stage 2
  pfp_pkg::interp_ctl_t hyp_ctl;
  logic [TAB_W-1:0]     cosh_a, sinh_a;

  assign hyp_ctl.ld_lut = load[1];
  assign hyp_ctl.ld_mix = load[2];

  pfp_hyp_interp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .FRAC_BITS     (FRAC_BITS)
  ) u_hyp (
    .clk    (clk),
    .ctl    (hyp_ctl),
    .r      (rem_nxt),
    .cosh_a (cosh_a),
    .sinh_a (sinh_a)
  );

  always_ff @(posedge clk) begin
    if (load[2]) begin
      item2_r <= item1_r;
      sat2_r  <= sat1_r;
    end
  end

  // ---------------------------------------------------------------- stage 3
  // ks = coth*sinh(a), kc = KL*cosh(a), rounded half up
  logic [KM_W-1:0]   ks_prod, kc_prod;
  logic [COEF_W-1:0] ks_nxt, kc_nxt;
  logic [COEF_W-1:0] ks_r, kc_r;

  always_comb begin
    ks_prod = KM_W'(COTH_C) * KM_W'(sinh_a) + HALF_F;
    kc_prod = KM_W'(KL_C) * KM_W'(cosh_a) + HALF_F;
    ks_nxt  = ks_prod[FRAC_BITS +: COEF_W];
    kc_nxt  = kc_prod[FRAC_BITS +: COEF_W];
  end

  always_ff @(posedge clk) begin
    if (load[3]) begin
      ks_r    <= ks_nxt;
      kc_r    <= kc_nxt;
      item3_r <= item2_r;
      sat3_r  <= sat2_r;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // mixed pairing: x uses position_x with momentum_y, y the other way round
  logic signed [COEF_W:0]   ks_s, kc_s;
  logic signed [PROD_W-1:0] pvx_r, psx_r, pcx_r, ppy_r, psy_r, pcy_r;

  assign ks_s = {1'b0, ks_r};
  assign kc_s = {1'b0, kc_r};

  always_ff @(posedge clk) begin
    if (load[4]) begin
      pvx_r  <= KV_S * item3_r.tgt_vx;
      psx_r  <= ks_s * item3_r.pos_x;
      pcx_r  <= kc_s * item3_r.mom_y;
      ppy_r  <= KP_S * item3_r.tgt_oy;
      psy_r  <= ks_s * item3_r.pos_y;
      pcy_r  <= kc_s * item3_r.mom_x;
      sat4_r <= sat3_r;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic signed [ACC_W-1:0] accx_nxt, accy_nxt, accx_r, accy_r;

  assign accx_nxt = ACC_W'(pvx_r) - ACC_W'(psx_r) - ACC_W'(pcx_r);
  assign accy_nxt = ACC_W'(ppy_r) - ACC_W'(psy_r) - ACC_W'(pcy_r);

  always_ff @(posedge clk) begin
    if (load[5]) begin
      accx_r <= accx_nxt;
      accy_r <= accy_nxt;
      sat5_r <= sat4_r;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // round half up to Q16.16, clamp to 32 bits
  logic signed [ACC_W-1:0] rndx, rndy;
  logic        [RS_W-1:0]  rsx, rsy;
  logic                    ovx, ovy;
  logic signed [DW-1:0]    fx_nxt, fy_nxt;
  logic signed [DW-1:0]    foot_x_r, foot_y_r;
  logic                    sat_r;

  always_comb begin
    rndx   = accx_r + ROUND_F;
    rndy   = accy_r + ROUND_F;
    rsx    = rndx[ACC_W-1:FRAC_BITS];
    rsy    = rndy[ACC_W-1:FRAC_BITS];
    ovx    = !((&rsx[RS_W-1:DW-1]) || !(|rsx[RS_W-1:DW-1]));
    ovy    = !((&rsy[RS_W-1:DW-1]) || !(|rsy[RS_W-1:DW-1]));
    fx_nxt = ovx ? (rsx[RS_W-1] ? SAT_MIN : SAT_MAX) : rsx[DW-1:0];
    fy_nxt = ovy ? (rsy[RS_W-1] ? SAT_MIN : SAT_MAX) : rsy[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (load[6]) begin
      foot_x_r <= fx_nxt;
      foot_y_r <= fy_nxt;
      sat_r    <= sat5_r || ovx || ovy;
    end
  end

  assign out_valid     = vld_r[NS];
  assign out_foot_x    = foot_x_r;
  assign out_foot_y    = foot_y_r;
  assign out_saturated = sat_r;

  // ---------------------------------------------------------------- checks
  // an empty output stage never holds back the input
  a_no_block : assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NS] |-> in_ready)
    else $error("input stalled with empty output stage");

  // an accepted item lands in the first stage
  a_enter : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[1])
    else $error("accepted item missing from first stage");

  // a blocked coefficient stage keeps its item and data
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[3] && !take[3]) |=> (vld_r[3] && $stable(ks_r) && $stable(kc_r)))
    else $error("stalled item lost in coefficient stage");

endmodule

/* design/pfp_hyp_interp.sv */
// ----------------------------------------------------------------------------
// pfp_hyp_interp: cosh/sinh of the remaining-time argument
// Two pipeline stages: registered table read, then linear interpolation.
// ----------------------------------------------------------------------------
module pfp_hyp_interp #(
  parameter int TABLE_ENTRIES = pfp_pkg::TABLE_ENTRIES_DEF,
  parameter int FRAC_BITS     = pfp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  pfp_pkg::interp_ctl_t                ctl,
  input  logic [pfp_pkg::PHASE_W-1:0]         r,
  output logic [FRAC_BITS+2:0]                cosh_a,
  output logic [FRAC_BITS+2:0]                sinh_a
);

  localparam int TAB_W  = FRAC_BITS + 3;
  localparam int FR_W   = pfp_pkg::PHASE_FRAC_W;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int POS_W  = pfp_pkg::PHASE_W + IDX_W;
  localparam int MIX_W  = TAB_W + FR_W + 1;
  localparam logic [63:0] HALF_Q = 64'd1 << (29 - FRAC_BITS);
  localparam logic [MIX_W-1:0] HALF_FR = MIX_W'(1) << (FR_W - 1);

  logic [TAB_W-1:0] cosh_lo_rom [TABLE_ENTRIES+1];
  logic [TAB_W-1:0] cosh_dl_rom [TABLE_ENTRIES+1];
  logic [TAB_W-1:0] sinh_lo_rom [TABLE_ENTRIES+1];
  logic [TAB_W-1:0] sinh_dl_rom [TABLE_ENTRIES+1];

  // each entry carries its value and the clamped step to the next one
  for (genvar g = 0; g <= TABLE_ENTRIES; g++) begin : g_rom
    localparam int GN = (g < TABLE_ENTRIES) ? g + 1 : g;
    localparam logic [63:0] X_LO = (pfp_pkg::LTW_Q30 * 64'(g)
                                    + 64'(TABLE_ENTRIES / 2)) / 64'(TABLE_ENTRIES);
    localparam logic [63:0] X_HI = (pfp_pkg::LTW_Q30 * 64'(GN)
                                    + 64'(TABLE_ENTRIES / 2)) / 64'(TABLE_ENTRIES);
    localparam pfp_pkg::hyp_t H_LO = pfp_pkg::hyp_q30(X_LO);
    localparam pfp_pkg::hyp_t H_HI = pfp_pkg::hyp_q30(X_HI);
    localparam logic [63:0] C_LO = (H_LO.ch + HALF_Q) >> (30 - FRAC_BITS);
    localparam logic [63:0] C_HI = (H_HI.ch + HALF_Q) >> (30 - FRAC_BITS);
    localparam logic [63:0] S_LO = (H_LO.sh + HALF_Q) >> (30 - FRAC_BITS);
    localparam logic [63:0] S_HI = (H_HI.sh + HALF_Q) >> (30 - FRAC_BITS);
    localparam logic [63:0] C_DL = (C_HI > C_LO) ? C_HI - C_LO : 64'd0;
    localparam logic [63:0] S_DL = (S_HI > S_LO) ? S_HI - S_LO : 64'd0;
    assign cosh_lo_rom[g] = C_LO[TAB_W-1:0];
    assign cosh_dl_rom[g] = C_DL[TAB_W-1:0];
    assign sinh_lo_rom[g] = S_LO[TAB_W-1:0];
    assign sinh_dl_rom[g] = S_DL[TAB_W-1:0];
  end

  logic [POS_W-1:0] pos_nxt;
  logic [IDX_W-1:0] idx_nxt;

  logic [TAB_W-1:0] c_lo_r, c_dl_r, s_lo_r, s_dl_r;
  logic [FR_W-1:0]  fr_r;
  logic [MIX_W-1:0] c_prod, s_prod;
  logic [TAB_W-1:0] cosh_nxt, sinh_nxt;
  logic [TAB_W-1:0] cosh_r, sinh_r;

  // position in table; pos >> 16 never exceeds TABLE_ENTRIES
  assign pos_nxt = POS_W'(r) * POS_W'(TABLE_ENTRIES);
  assign idx_nxt = pos_nxt[FR_W +: IDX_W];

  always_ff @(posedge clk) begin
    if (ctl.ld_lut) begin
      c_lo_r <= cosh_lo_rom[idx_nxt];
      c_dl_r <= cosh_dl_rom[idx_nxt];
      s_lo_r <= sinh_lo_rom[idx_nxt];
      s_dl_r <= sinh_dl_rom[idx_nxt];
      fr_r   <= pos_nxt[FR_W-1:0];
    end
  end

  always_comb begin
    c_prod   = MIX_W'(c_dl_r) * MIX_W'(fr_r) + HALF_FR;
    s_prod   = MIX_W'(s_dl_r) * MIX_W'(fr_r) + HALF_FR;
    cosh_nxt = c_lo_r + c_prod[FR_W +: TAB_W];
    sinh_nxt = s_lo_r + s_prod[FR_W +: TAB_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_mix) begin
      cosh_r <= cosh_nxt;
      sinh_r <= sinh_nxt;
    end
  end

  assign cosh_a = cosh_r;
  assign sinh_a = sinh_r;

endmodule
